// ===== sv/request_tag_tracker_core_defines.svh =====
// assertion macros for the request tag tracker
`ifndef REQUEST_TAG_TRACKER_CORE_DEFINES_SVH
`define REQUEST_TAG_TRACKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define RTT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtt check failed");

// next-cycle implication, checked out of reset
`define RTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtt check failed");

`else

`define RTT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RTT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/rtt_pkg.sv =====
// shared types and constants for the request tag tracker
package rtt_pkg;

  localparam int CAPACITY_DEF = 8;

  localparam int TAG_W  = 32;
  localparam int ACT_W  = 2;
  localparam int KIND_W = 3;
  localparam int OUTC_W = 2;

  localparam logic [ACT_W-1:0] ACT_RESERVE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PUBLISH = 2'd2;
  localparam logic [ACT_W-1:0] ACT_POP     = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic bump;
    logic compare;
    logic do_reserve;
    logic do_release;
    logic do_publish;
    logic do_pop;
    logic reject;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             room;
    logic             ring_full;
    logic             ring_empty;
    logic             tag_nz;
    logic             pub_args_ok;
    logic             slot_hit;
    logic             cand_bad;
  } sts_t;

endpackage

// ===== sv/rtt_ctrl.sv =====
// sequencing state machine for the request tag tracker
module rtt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rtt_pkg::sts_t sts,
  output rtt_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_CMP    = 2'd2;
  localparam logic [1:0] S_EVAL   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.action)
          rtt_pkg::ACT_RESERVE: begin
            if (sts.room) begin
              cmd.bump  = 1'b1;
              state_nxt = S_CMP;
            end else begin
              cmd.reject = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
          rtt_pkg::ACT_POP: begin
            if (!sts.ring_empty) begin
              cmd.do_pop = 1'b1;
            end else begin
              cmd.reject = 1'b1;
            end
            state_nxt = S_IDLE;
          end
          default: begin
            state_nxt = S_CMP;
          end
        endcase
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_IDLE;
        case (sts.action)
          rtt_pkg::ACT_RESERVE: begin
            if (sts.cand_bad) begin
              cmd.bump  = 1'b1;
              state_nxt = S_CMP;
            end else begin
              cmd.do_reserve = 1'b1;
            end
          end
          rtt_pkg::ACT_RELEASE: begin
            if (sts.tag_nz && sts.slot_hit) begin
              cmd.do_release = 1'b1;
            end else begin
              cmd.reject = 1'b1;
            end
          end
          rtt_pkg::ACT_PUBLISH: begin
            if (sts.pub_args_ok && sts.slot_hit && !sts.ring_full) begin
              cmd.do_publish = 1'b1;
            end else begin
              cmd.reject = 1'b1;
            end
          end
          default: begin
            cmd.reject = 1'b1;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/rtt_datapath.sv =====
// tag table, result fifo, id counter and result registers
module rtt_datapath #(
  parameter int CAPACITY = rtt_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [rtt_pkg::ACT_W-1:0]  in_action,
  input  logic [rtt_pkg::TAG_W-1:0]  in_req_tag,
  input  logic [rtt_pkg::KIND_W-1:0] in_op_kind,
  input  logic [rtt_pkg::OUTC_W-1:0] in_op_outcome,
  input  logic                       in_sim_busy,
  input  rtt_pkg::cmd_t              cmd,
  output rtt_pkg::sts_t              sts,
  output logic                       out_valid,
  output logic                       out_success,
  output logic [rtt_pkg::TAG_W-1:0]  out_tag,
  output logic [rtt_pkg::KIND_W-1:0] out_kind,
  output logic [rtt_pkg::OUTC_W-1:0] out_outcome,
  output logic                       out_sim_busy
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  // latched word
  logic [rtt_pkg::ACT_W-1:0]  act_r;
  logic [rtt_pkg::TAG_W-1:0]  tag_r;
  logic [rtt_pkg::KIND_W-1:0] kind_r;
  logic [rtt_pkg::OUTC_W-1:0] outc_r;
  logic                       sim_r;

  logic [rtt_pkg::TAG_W-1:0]  ctr_r;

  // reservation table
  logic [rtt_pkg::TAG_W-1:0]  slot_tag_r [CAPACITY];
  logic [CAPACITY-1:0]        slot_used_r;
  logic [CNT_W-1:0]           total_r;

  // result fifo
  logic [rtt_pkg::TAG_W-1:0]  ring_tag_r  [CAPACITY];
  logic [rtt_pkg::KIND_W-1:0] ring_kind_r [CAPACITY];
  logic [rtt_pkg::OUTC_W-1:0] ring_outc_r [CAPACITY];
  logic                       ring_sim_r  [CAPACITY];
  logic [CAPACITY-1:0]        ring_occ_r;
  logic [IDX_W-1:0]           head_r;
  logic [IDX_W-1:0]           tail_r;
  logic [CNT_W-1:0]           fill_r;

  logic [CAPACITY-1:0]        slot_hit_r;
  logic [CAPACITY-1:0]        ring_hit_r;

  logic                       out_valid_r;
  logic                       out_success_r;
  logic [rtt_pkg::TAG_W-1:0]  out_tag_r;
  logic [rtt_pkg::KIND_W-1:0] out_kind_r;
  logic [rtt_pkg::OUTC_W-1:0] out_outc_r;
  logic                       out_sim_r;

  logic [rtt_pkg::TAG_W-1:0]  key;
  logic [IDX_W-1:0]           free_idx;
  logic [IDX_W-1:0]           hit_idx;
  logic [IDX_W-1:0]           head_inc;
  logic [IDX_W-1:0]           tail_inc;
  logic [CNT_W:0]             live_sum;
  logic                       respond;

  assign key      = (act_r == rtt_pkg::ACT_RESERVE) ? ctr_r : tag_r;
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + IDX_W'(1);
  assign tail_inc = (tail_r == LAST_IDX) ? '0 : tail_r + IDX_W'(1);
  assign live_sum = {1'b0, total_r} + {1'b0, fill_r};
  assign respond  = cmd.do_reserve | cmd.do_release | cmd.do_publish | cmd.do_pop |
                    cmd.reject;

  // lowest free slot and lowest matching slot
  always_comb begin
    free_idx = '0;
    hit_idx  = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!slot_used_r[i]) begin
        free_idx = IDX_W'(i);
      end
      if (slot_hit_r[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    sts.action      = act_r;
    sts.room        = (live_sum < (CNT_W + 1)'(CAPACITY));
    sts.ring_full   = (fill_r == CNT_W'(CAPACITY));
    sts.ring_empty  = (fill_r == '0);
    sts.tag_nz      = (tag_r != '0);
    sts.pub_args_ok = (tag_r != '0) && (kind_r != '0) && (outc_r != '0);
    sts.slot_hit    = |slot_hit_r;
    sts.cand_bad    = (ctr_r == '0) || (|slot_hit_r) || (|ring_hit_r);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r       <= '0;
      slot_used_r <= '0;
      total_r     <= '0;
      ring_occ_r  <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= respond;
      if (cmd.bump) begin
        ctr_r <= ctr_r + rtt_pkg::TAG_W'(1);
      end
      if (cmd.do_reserve) begin
        slot_used_r[free_idx] <= 1'b1;
        total_r               <= total_r + CNT_W'(1);
      end
      if (cmd.do_release) begin
        slot_used_r[hit_idx] <= 1'b0;
        total_r              <= total_r - CNT_W'(1);
      end
      if (cmd.do_publish) begin
        slot_used_r[hit_idx] <= 1'b0;
        total_r              <= total_r - CNT_W'(1);
        ring_occ_r[tail_r]   <= 1'b1;
        tail_r               <= tail_inc;
        fill_r               <= fill_r + CNT_W'(1);
      end
      if (cmd.do_pop) begin
        ring_occ_r[head_r] <= 1'b0;
        head_r             <= head_inc;
        fill_r             <= fill_r - CNT_W'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      tag_r  <= in_req_tag;
      kind_r <= in_op_kind;
      outc_r <= in_op_outcome;
      sim_r  <= in_sim_busy;
    end
    if (cmd.compare) begin
      for (int i = 0; i < CAPACITY; i++) begin
        slot_hit_r[i] <= slot_used_r[i] && (slot_tag_r[i] == key);
        ring_hit_r[i] <= ring_occ_r[i] && (ring_tag_r[i] == key);
      end
    end
    if (cmd.do_reserve) begin
      slot_tag_r[free_idx] <= ctr_r;
    end
    if (cmd.do_publish) begin
      ring_tag_r[tail_r]  <= tag_r;
      ring_kind_r[tail_r] <= kind_r;
      ring_outc_r[tail_r] <= outc_r;
      ring_sim_r[tail_r]  <= sim_r;
    end
    if (respond) begin
      out_success_r <= !cmd.reject;
      out_tag_r     <= cmd.do_reserve ? ctr_r :
                       cmd.do_pop     ? ring_tag_r[head_r] : '0;
      out_kind_r    <= cmd.do_pop ? ring_kind_r[head_r] : '0;
      out_outc_r    <= cmd.do_pop ? ring_outc_r[head_r] : '0;
      out_sim_r     <= cmd.do_pop ? ring_sim_r[head_r] : 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_success  = out_success_r;
  assign out_tag      = out_tag_r;
  assign out_kind     = out_kind_r;
  assign out_outcome  = out_outc_r;
  assign out_sim_busy = out_sim_r;

endmodule

// ===== sv/request_tag_tracker_core.sv =====
// top level of the request tag tracker
//
//  channel   ports                                         handshake
//  -------   -------------------------------------------   -----------------------
//  in        in_action in_req_tag in_op_kind                start high, busy low
//            in_op_outcome in_sim_busy
//  out       out_success out_tag out_kind out_outcome      out_valid, one cycle
//            out_sim_busy
//
//  reserve: decode, then a compare pass and an evaluate step, repeated for every candidate
//    tag that is zero or still live (one compare pass per candidate)
//  release and publish: decode, compare pass, evaluate
//  pop, and a reserve with no room: settled in decode
//  the result strobe rides in the first cycle busy is low again; it cannot be stalled
//  rst_n is synchronous; it empties the tag table and fifo and zeroes the counter
`include "request_tag_tracker_core_defines.svh"

module request_tag_tracker_core #(
  parameter int CAPACITY = rtt_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input word
  input  logic                       start,
  output logic                       busy,
  input  logic [rtt_pkg::ACT_W-1:0]  in_action,
  input  logic [rtt_pkg::TAG_W-1:0]  in_req_tag,
  input  logic [rtt_pkg::KIND_W-1:0] in_op_kind,
  input  logic [rtt_pkg::OUTC_W-1:0] in_op_outcome,
  input  logic                       in_sim_busy,
  // result word
  output logic                       out_valid,
  output logic                       out_success,
  output logic [rtt_pkg::TAG_W-1:0]  out_tag,
  output logic [rtt_pkg::KIND_W-1:0] out_kind,
  output logic [rtt_pkg::OUTC_W-1:0] out_outcome,
  output logic                       out_sim_busy
);

  // command and status between sequencer and datapath
  rtt_pkg::cmd_t cmd;
  rtt_pkg::sts_t sts;

  logic in_fire;

  assign in_fire = start && !busy;

  // sequencer: decode, compare pass, evaluate, retry loop for reserve
  rtt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // tag table, result fifo, id counter, parallel tag compare, result registers
  rtt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_action     (in_action),
    .in_req_tag    (in_req_tag),
    .in_op_kind    (in_op_kind),
    .in_op_outcome (in_op_outcome),
    .in_sim_busy   (in_sim_busy),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_success   (out_success),
    .out_tag       (out_tag),
    .out_kind      (out_kind),
    .out_outcome   (out_outcome),
    .out_sim_busy  (out_sim_busy)
  );

  // a result only shows once the sequencer is back in idle
  `RTT_ASSERT_SAME(a_strobe_idle, clk, rst_n, out_valid, !busy)

  // an accepted word makes the block busy with no stale strobe
  `RTT_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_fire, busy && !out_valid)

  // the fifo is never popped empty
  `RTT_ASSERT_SAME(a_pop_nonempty, clk, rst_n, cmd.do_pop, !sts.ring_empty)

  // a publish needs a reserved tag and fifo space
  `RTT_ASSERT_SAME(a_publish_ok, clk, rst_n, cmd.do_publish,
                   sts.slot_hit && !sts.ring_full)

endmodule
